/* hw/rtl/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg: shared types and codes of the double-ended queue
// Operation and status codes, plus the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int OPCODE_W = 2;
	localparam int STATUS_W = 2;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 5;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_REAR  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_REAR   = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Value shown for a missing entry or a push
	localparam logic signed [VALUE_W-1:0] NO_VALUE = '1;

	// Controller to datapath
	typedef struct packed {
		logic exec;   // carry out the accepted request this cycle
		logic fill;   // load the cached end from the store read data
	} deq_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_fill;  // the presented request empties a cached end that must be reread
	} deq_sts_t;

endpackage

/* hw/rtl/deq_if.sv */
// ----------------------------------------------------------------------------
// deq_req_if / deq_rsp_if: request and result channels
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface deq_req_if import deq_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [OPCODE_W-1:0]        opcode;
	logic signed [VALUE_W-1:0]  push_value;

	modport source (output valid, opcode, push_value, input ready);
	modport sink   (input valid, opcode, push_value, output ready);
endinterface

interface deq_rsp_if import deq_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [VALUE_W-1:0]  popped_value;
	logic [STATUS_W-1:0]        status;
	logic signed [VALUE_W-1:0]  front_value;
	logic signed [VALUE_W-1:0]  rear_value;
	logic                       is_empty;
	logic [COUNT_W-1:0]         entry_count;

	modport source (output valid, popped_value, status, front_value, rear_value,
		is_empty, entry_count, input ready);
	modport sink   (input valid, popped_value, status, front_value, rear_value,
		is_empty, entry_count, output ready);
endinterface

/* hw/rtl/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit values
// Ring buffer with push/pop at either end and one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   req: valid/ready channel carrying opcode (push front, push rear, pop
//        front, pop rear) and push_value.
//   rsp: valid/ready channel with one result per request: popped value,
//        status (ok, pop on empty, push on full), and the front value, rear
//        value, empty flag and entry count after the request.
//   Timing: a push, or a pop that finds at most one entry, shows its result
//   the cycle after acceptance; any other pop waits in a fill state while
//   the new end value is reread through the registered store read port.
//   Acceptance: one request at a time, held back by that fill state; a new
//   request is taken in the cycle its predecessor's result is taken.
//   Reset clears the pointers and count (queue empty); store contents are
//   undefined until written. While rsp is stalled the result holds and req
//   stays not ready.
// ----------------------------------------------------------------------------
module double_ended_queue import deq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	deq_req_if.sink    req,
	deq_rsp_if.source  rsp
);

	deq_cmd_t cmd;
	deq_sts_t sts;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	deq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.opcode       (req.opcode),
		.push_value   (req.push_value),
		.popped_value (rsp.popped_value),
		.status       (rsp.status),
		.front_value  (rsp.front_value),
		.rear_value   (rsp.rear_value),
		.is_empty     (rsp.is_empty),
		.entry_count  (rsp.entry_count)
	);

endmodule

/* hw/rtl/deq_ctrl.sv */
// ----------------------------------------------------------------------------
// deq_ctrl: request sequencer
// Accepts a request when the result slot is free, waits in S_FILL for the
// store read when a pop must refill a cached end, and owns the result valid.
// ----------------------------------------------------------------------------
module deq_ctrl import deq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  deq_sts_t sts,
	output deq_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_FILL
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// Take a request only while idle and the result slot is empty or drains this cycle
	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign cmd.exec  = in_valid && in_ready;
	assign cmd.fill  = (state_q == S_FILL);
	assign out_valid = out_valid_q;

	// Advance state and hold the result valid until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
					end
					if (cmd.exec) begin
						if (sts.need_fill) begin
							state_q     <= S_FILL;
							out_valid_q <= 1'b0;
						end else begin
							out_valid_q <= 1'b1;
						end
					end
				end
				S_FILL: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/deq_dp.sv */
// ----------------------------------------------------------------------------
// deq_dp: ring buffer datapath
// Ring store with one write and one registered read port, head/tail pointers,
// entry count, cached front and rear values and the result registers.
// ----------------------------------------------------------------------------
module deq_dp import deq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  deq_cmd_t                   cmd,
	output deq_sts_t                   sts,
	input  logic [OPCODE_W-1:0]        opcode,
	input  logic signed [VALUE_W-1:0]  push_value,
	output logic signed [VALUE_W-1:0]  popped_value,
	output logic [STATUS_W-1:0]        status,
	output logic signed [VALUE_W-1:0]  front_value,
	output logic signed [VALUE_W-1:0]  rear_value,
	output logic                       is_empty,
	output logic [COUNT_W-1:0]         entry_count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	logic signed [VALUE_W-1:0] ring_mem [DEPTH];
	logic signed [VALUE_W-1:0] rd_q;

	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	logic          fill_front_q;
	logic signed [VALUE_W-1:0] front_q, rear_q;
	logic signed [VALUE_W-1:0] popped_q;
	status_t       status_q;

	opcode_t       op;
	logic          empty, full;
	logic [AW-1:0] head_next, head_prev, tail_next, tail_prev, tail_prev2;
	logic [AW-1:0] rd_addr, wr_addr;
	logic          wr_en;
	logic [XW-1:0] count_x;

	// Decode the request and neighbor slots of both pointers
	always_comb begin
		op         = opcode_t'(opcode);
		empty      = (count_q == '0);
		full       = (count_q == FULL);
		head_next  = (head_q == LAST) ? '0 : head_q + 1'b1;
		head_prev  = (head_q == '0) ? LAST : head_q - 1'b1;
		tail_next  = (tail_q == LAST) ? '0 : tail_q + 1'b1;
		tail_prev  = (tail_q == '0) ? LAST : tail_q - 1'b1;
		tail_prev2 = (tail_prev == '0) ? LAST : tail_prev - 1'b1;
		rd_addr    = (op == OP_POP_FRONT) ? head_next : tail_prev2;
		wr_addr    = (op == OP_PUSH_FRONT) ? head_prev : tail_q;
		wr_en      = cmd.exec && !full
			&& (op == OP_PUSH_FRONT || op == OP_PUSH_REAR);
		// A pop that leaves entries behind must reread the new end
		sts.need_fill = (op == OP_POP_FRONT || op == OP_POP_REAR)
			&& (count_q > CW'(1));
	end

	// Ring store: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[wr_addr] <= push_value;
		end
		rd_q <= ring_mem[rd_addr];
	end

	// Update pointers and count on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			case (op)
				OP_PUSH_FRONT: begin
					if (!full) begin
						head_q  <= head_prev;
						count_q <= count_q + 1'b1;
					end
				end
				OP_PUSH_REAR: begin
					if (!full) begin
						tail_q  <= tail_next;
						count_q <= count_q + 1'b1;
					end
				end
				OP_POP_FRONT: begin
					if (!empty) begin
						head_q  <= head_next;
						count_q <= count_q - 1'b1;
					end
				end
				OP_POP_REAR: begin
					if (!empty) begin
						tail_q  <= tail_prev;
						count_q <= count_q - 1'b1;
					end
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// Hold cached ends and the result payload
	always_ff @(posedge clk) begin
		if (cmd.fill) begin
			if (fill_front_q) begin
				front_q <= rd_q;
			end else begin
				rear_q <= rd_q;
			end
		end else if (cmd.exec) begin
			popped_q     <= NO_VALUE;
			status_q     <= ST_OK;
			fill_front_q <= (op == OP_POP_FRONT);
			case (op)
				OP_PUSH_FRONT: begin
					if (full) begin
						status_q <= ST_FULL;
					end else begin
						front_q <= push_value;
						if (empty) begin
							rear_q <= push_value;
						end
					end
				end
				OP_PUSH_REAR: begin
					if (full) begin
						status_q <= ST_FULL;
					end else begin
						rear_q <= push_value;
						if (empty) begin
							front_q <= push_value;
						end
					end
				end
				OP_POP_FRONT: begin
					if (empty) begin
						status_q <= ST_EMPTY;
					end else begin
						popped_q <= front_q;
					end
				end
				OP_POP_REAR: begin
					if (empty) begin
						status_q <= ST_EMPTY;
					end else begin
						popped_q <= rear_q;
					end
				end
				default: begin
					status_q <= ST_OK;
				end
			endcase
		end
	end

	// Drive the result; the queue state holds until the result is taken
	assign count_x      = XW'(count_q);
	assign popped_value = popped_q;
	assign status       = status_q;
	assign is_empty     = empty;
	assign front_value  = empty ? NO_VALUE : front_q;
	assign rear_value   = empty ? NO_VALUE : rear_q;
	assign entry_count  = count_x[COUNT_W-1:0];

endmodule
